@@ hw/rtl/dedup_fifo_queue_defines.svh @@
// Assertion macros for the checker of the duplicate-rejecting queue
`ifndef DEDUP_FIFO_QUEUE_DEFINES_SVH
`define DEDUP_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/dfq_pkg.sv @@
// Types, constants and helpers shared by the duplicate-rejecting queue
`timescale 1ns / 1ps
package dfq_pkg;

   localparam int DEPTH  = 128;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OCC_W  = 8;

   typedef logic [IDX_W-1:0]         dfq_idx_type;
   typedef logic [CNT_W-1:0]         dfq_cnt_type;
   typedef logic signed [DATA_W-1:0] dfq_data_type;

   localparam dfq_cnt_type FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } dfq_op_type;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_DUP   = 3'd1,
      STATUS_FULL  = 3'd2,
      STATUS_EMPTY = 3'd3,
      STATUS_ZERO  = 3'd4
   } dfq_status_type;

   // clear: restart the duplicate flag; probe: a scan read is issued this cycle
   typedef struct packed {
      logic clear;
      logic probe;
   } dfq_match_ctl_type;

   // Ring pointer advance with wrap at the last slot
   function automatic dfq_idx_type dfq_next_idx(dfq_idx_type idx);
      dfq_idx_type nxt;
      if (idx == IDX_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

endpackage

@@ hw/rtl/dedup_fifo_queue.sv @@
// Top level: bounded FIFO of signed words that rejects duplicates
//
//  channel | dir | ports                                            | handshake
//  --------+-----+--------------------------------------------------+---------------------
//  request | in  | req_operation, req_value                         | start && !busy
//  result  | out | rsp_dequeued_value, rsp_status, rsp_occupancy    | rsp_valid, one cycle
//
// Enqueue of zero, dequeue of an empty queue and enqueue into an empty queue answer
// the cycle after acceptance. Dequeues answer from ST_DEQ; other enqueues scan the
// held entries and answer from ST_DECIDE: the entries go past the single comparator
// one per cycle through the one read port of the entry RAM. Reset is synchronous
// and empties the queue; entries are not cleared. Results cannot be held off.
`timescale 1ns / 1ps
module dedup_fifo_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dfq_pkg::dfq_op_type           req_operation,
   input  dfq_pkg::dfq_data_type         req_value,
   output logic                          rsp_valid,
   output dfq_pkg::dfq_data_type         rsp_dequeued_value,
   output dfq_pkg::dfq_status_type       rsp_status,
   output logic [dfq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import dfq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DEQ
   } state_type;

   state_type      state_ff, state_in;
   dfq_idx_type    head_ff, head_in;
   dfq_cnt_type    count_ff, count_in;
   dfq_idx_type    rp_ff, rp_in;
   dfq_cnt_type    scan_ff, scan_in;
   dfq_data_type   key_ff, key_in;
   logic           rsp_valid_ff, rsp_valid_in;
   dfq_data_type   rsp_value_ff, rsp_value_in;
   dfq_status_type rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic              accept;
   logic              ram_wr_en;
   dfq_idx_type       ram_wr_addr;
   dfq_data_type      ram_wr_data;
   logic              ram_rd_en;
   dfq_idx_type       ram_rd_addr;
   dfq_data_type      ram_rd_data;
   dfq_match_ctl_type match_ctl;
   logic              dup;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rp_in         = rp_ff;
      scan_in       = scan_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head_ff;
      ram_wr_data   = key_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rp_ff;
      match_ctl     = '{clear: 1'b0, probe: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in          = req_value;
               match_ctl.clear = 1'b1;
               if (req_operation == OP_DEQ) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     state_in    = ST_DEQ;
                  end
               end else if (req_value == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_ZERO;
               end else if (count_ff == '0) begin
                  // nothing to compare against: store at once
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = head_ff;
                  ram_wr_data   = req_value;
                  count_in      = CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_OK;
               end else begin
                  ram_rd_en       = 1'b1;
                  ram_rd_addr     = head_ff;
                  match_ctl.probe = 1'b1;
                  rp_in           = dfq_next_idx(head_ff);
                  scan_in         = CNT_W'(1);
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff != count_ff) begin
               ram_rd_en       = 1'b1;
               ram_rd_addr     = rp_ff;
               match_ctl.probe = 1'b1;
               rp_in           = dfq_next_idx(rp_ff);
               scan_in         = scan_ff + CNT_W'(1);
            end else begin
               // last compare completes this cycle; rp now sits on the tail slot
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            state_in     = ST_IDLE;
            if (dup) begin
               rsp_status_in = STATUS_DUP;
            end else if (count_ff == FULL_COUNT) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = rp_ff;
               ram_wr_data   = key_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_status_in = STATUS_OK;
            end
         end
         ST_DEQ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = ram_rd_data;
            rsp_status_in = STATUS_OK;
            head_in       = dfq_next_idx(head_ff);
            count_in      = count_ff - CNT_W'(1);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_occ_in = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rp_ff         <= rp_in;
      scan_ff       <= scan_in;
      key_ff        <= key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   dfq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dfq_match u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (match_ctl),
      .rd_data (ram_rd_data),
      .key     (key_ff),
      .dup     (dup)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dequeued_value = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occupancy      = rsp_occ_ff;

endmodule

@@ hw/rtl/dfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module dfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dfq_match.sv @@
// Shared comparator: checks each scanned word against the key, keeps a sticky hit
`timescale 1ns / 1ps
module dfq_match (
   input  logic                       clock,
   input  logic                       reset,
   input  dfq_pkg::dfq_match_ctl_type ctl,
   input  dfq_pkg::dfq_data_type      rd_data,
   input  dfq_pkg::dfq_data_type      key,
   output logic                       dup
);
   import dfq_pkg::*;

   logic probe_ff;
   logic probe_in;
   logic dup_ff;
   logic dup_in;

   // RAM read data is registered, so delay the probe tag to match
   always_comb begin
      probe_in = ctl.probe;
      if (ctl.clear) begin
         dup_in = 1'b0;
      end else begin
         dup_in = dup_ff | (probe_ff & (rd_data == key));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else begin
         probe_ff <= probe_in;
         dup_ff   <= dup_in;
      end
   end

   assign dup = dup_ff;

endmodule

@@ hw/rtl/dfq_checker.sv @@
// Port-level checker for the duplicate-rejecting queue, bound to the top level
`timescale 1ns / 1ps
`include "dedup_fifo_queue_defines.svh"
module dfq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input dfq_pkg::dfq_op_type       req_operation,
   input dfq_pkg::dfq_data_type     req_value,
   input logic                      rsp_valid,
   input dfq_pkg::dfq_data_type     rsp_dequeued_value,
   input dfq_pkg::dfq_status_type   rsp_status,
   input logic [dfq_pkg::OCC_W-1:0] rsp_occupancy
);
   import dfq_pkg::*;

   // every accepted word either answers next cycle or keeps the block busy
   `DFQ_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "accepted word neither answered nor in progress")
   // a long operation always ends in a result
   `DFQ_ASSERT_NOW(a_busy_ends_in_result, clock, reset, $fell(busy), rsp_valid, "busy dropped without a result")
   `DFQ_ASSERT_NOW(a_result_when_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")
   // only a successful dequeue carries a value
   `DFQ_ASSERT_NOW(a_value_only_on_ok, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_dequeued_value == '0, "non-zero value on a refused operation")

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (.*);

@@ verif/dedup_fifo_queue_tb.sv @@
// Self-checking testbench for the duplicate-rejecting queue: shadow queue, directed and random words
`timescale 1ns / 1ps
module dedup_fifo_queue_tb;
   import dfq_pkg::*;

   localparam int ITEM_GOAL = 1650;
   localparam int SETTLE_CYCLES = 140;

   typedef struct {
      dfq_data_type   dequeued;
      dfq_status_type status;
      logic [OCC_W-1:0] occupancy;
   } queue_answer_type;

   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_kind_type;

   class queue_shadow_type;
      dfq_data_type slots [DEPTH];
      int unsigned head_slot;
      int unsigned held;
      queue_answer_type awaited [$];
      int unsigned mismatch_count;

      function new();
         head_slot = 0;
         held = 0;
         mismatch_count = 0;
      endfunction

      // Advance the shadow ring by one accepted word and queue its answer
      function void note_request(dfq_op_type op, dfq_data_type value);
         queue_answer_type ans;
         bit seen;
         int unsigned k;
         ans.dequeued = '0;
         seen = 1'b0;
         if (op == OP_DEQ) begin
            if (held == 0) begin
               ans.status = STATUS_EMPTY;
            end else begin
               ans.dequeued = slots[head_slot];
               head_slot = (head_slot + 1) % DEPTH;
               held--;
               ans.status = STATUS_OK;
            end
         end else if (value == '0) begin
            ans.status = STATUS_ZERO;
         end else begin
            for (k = 0; k < held; k++) begin
               if (slots[(head_slot + k) % DEPTH] == value) seen = 1'b1;
            end
            if (seen) begin
               ans.status = STATUS_DUP;
            end else if (held >= DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               slots[(head_slot + held) % DEPTH] = value;
               held++;
               ans.status = STATUS_OK;
            end
         end
         ans.occupancy = OCC_W'(held);
         awaited.push_back(ans);
      endfunction

      function void check_result(dfq_data_type dequeued, dfq_status_type status,
                                 logic [OCC_W-1:0] occupancy);
         queue_answer_type want;
         if (awaited.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing outstanding: value %h status %0d occ %0d",
                        $realtime, dequeued, status, occupancy);
            return;
         end
         want = awaited.pop_front();
         if (dequeued !== want.dequeued || status !== want.status ||
             occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: value exp %h got %h, status exp %0d got %0d, occ exp %0d got %0d",
                        $realtime, want.dequeued, dequeued, want.status, status,
                        want.occupancy, occupancy);
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function dfq_data_type pick_held();
         return slots[(head_slot + $urandom_range(0, held - 1)) % DEPTH];
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   dfq_op_type       req_operation;
   dfq_data_type     req_value;
   logic             rsp_valid;
   dfq_data_type     rsp_dequeued_value;
   dfq_status_type   rsp_status;
   logic [OCC_W-1:0] rsp_occupancy;

   queue_shadow_type shadow = new();
   int unsigned counted_words;

   dedup_fifo_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_dequeued_value (rsp_dequeued_value),
      .rsp_status         (rsp_status),
      .rsp_occupancy      (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         shadow.check_result(rsp_dequeued_value, rsp_status, rsp_occupancy);
      end
   end

   // Hold the word until the edge that takes it
   task automatic send_request(dfq_op_type op, dfq_data_type value);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_value <= value;
      do @(posedge clock); while (busy);
      shadow.note_request(op, value);
   endtask

   task automatic idle_gap(int unsigned cycles);
      if (cycles == 0) return;
      @(negedge clock);
      start <= 1'b0;
      req_operation <= dfq_op_type'($urandom_range(0, 1));
      req_value <= $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mix fresh, held, small-pool, extreme and zero values
   function automatic dfq_data_type choose_value(int unsigned dup_pct);
      int unsigned r;
      int s;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 4 + dup_pct && shadow.held > 0) return shadow.pick_held();
      if (r < 30) begin
         s = $urandom_range(0, 31);
         return dfq_data_type'(s - 16);
      end
      if (r < 36) begin
         case ($urandom_range(0, 3))
            0: return dfq_data_type'(32'h7FFF_FFFF);
            1: return dfq_data_type'(32'h8000_0000);
            2: return dfq_data_type'(32'hFFFF_FFFF);
            default: return dfq_data_type'(32'h0000_0001);
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_paced(dfq_op_type op, dfq_data_type value);
      send_request(op, value);
      idle_gap(gap_len());
   endtask

   task automatic run_directed();
      send_paced(OP_DEQ, '0);
      send_paced(OP_ENQ, '0);
      send_paced(OP_DEQ, dfq_data_type'(32'h1234_5678));
      send_paced(OP_ENQ, dfq_data_type'(32'h7FFF_FFFF));
      send_paced(OP_ENQ, dfq_data_type'(32'h8000_0000));
      send_paced(OP_ENQ, dfq_data_type'(32'hFFFF_FFFF));
      send_paced(OP_ENQ, dfq_data_type'(32'h0000_0001));
      send_paced(OP_ENQ, dfq_data_type'(32'h5555_5555));
      send_paced(OP_ENQ, dfq_data_type'(32'hAAAA_AAAA));
      // duplicates of the oldest, the newest and one in between
      send_paced(OP_ENQ, dfq_data_type'(32'h7FFF_FFFF));
      send_paced(OP_ENQ, dfq_data_type'(32'hAAAA_AAAA));
      send_paced(OP_ENQ, dfq_data_type'(32'hFFFF_FFFF));
      send_paced(OP_ENQ, '0);
      repeat (3) send_paced(OP_DEQ, $urandom);
      // a value removed is no longer a duplicate
      send_paced(OP_ENQ, dfq_data_type'(32'h7FFF_FFFF));
      repeat (5) send_paced(OP_DEQ, $urandom);
      send_paced(OP_DEQ, '0);
   endtask

   task automatic run_random();
      phase_kind_type kind;
      int unsigned length;
      int unsigned enq_pct;
      int unsigned dup_pct;
      int unsigned n;
      bit no_gaps;
      bit first;
      dfq_op_type op;
      dfq_data_type value;
      first = 1'b1;
      while (counted_words < ITEM_GOAL) begin
         // open with a fill so that the full cases come early
         kind = first ? PH_FILL : phase_kind_type'($urandom_range(0, 2));
         first = 1'b0;
         no_gaps = ($urandom_range(0, 3) == 0);
         case (kind)
            PH_FILL: begin
               length = $urandom_range(150, 220);
               enq_pct = 92;
               dup_pct = 10;
            end
            PH_DRAIN: begin
               length = $urandom_range(60, 160);
               enq_pct = 15;
               dup_pct = 25;
            end
            default: begin
               length = $urandom_range(40, 120);
               enq_pct = 50;
               dup_pct = 25;
            end
         endcase
         for (n = 0; n < length && counted_words < ITEM_GOAL; n++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            value = (op == OP_ENQ) ? choose_value(dup_pct) : dfq_data_type'($urandom);
            send_request(op, value);
            if (!(op == OP_ENQ && value == '0)) counted_words++;
            if (!no_gaps) idle_gap(gap_len());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ENQ;
      req_value = '0;
      counted_words = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.mismatch_count == 0 && shadow.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ dedup_fifo_queue.f @@
+incdir+hw/rtl
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_ram.sv
hw/rtl/dfq_match.sv
hw/rtl/dedup_fifo_queue.sv
hw/rtl/dfq_checker.sv
verif/dedup_fifo_queue_tb.sv
